// ===== rtl/core/pccs_pkg.sv =====
// Shared types and constants of the palette colour-cycle sequencer.
// Used by every module under rtl/core but pccs_ram; depends on nothing.
package pccs_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);
	localparam int WORD_W      = 16;

	localparam logic [WORD_W-1:0] WRAP_MARK = 16'h8000;

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_LOAD    = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic [1:0] REG_TABLE_LENGTH   = 2'd0;
	localparam logic [1:0] REG_RETRY_TICKS    = 2'd1;
	localparam logic [1:0] REG_WRITE_INTERVAL = 2'd2;

	localparam logic [6:0] TABLE_LENGTH_RESET   = 7'd0;
	localparam logic [7:0] RETRY_TICKS_RESET    = 8'd60;
	localparam logic [7:0] WRITE_INTERVAL_RESET = 8'd3;

	typedef enum logic [3:0] {
		K_TICK    = 4'b0001,
		K_LOAD    = 4'b0010,
		K_RESTART = 4'b0100,
		K_NOP     = 4'b1000
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [5:0]        idx;
		logic [WORD_W-1:0] value;
		logic              found;
		logic              owned;
	} cmd_t;

	typedef struct packed {
		logic              alive;
		logic              write_valid;
		logic [WORD_W-1:0] colour_word;
		logic [5:0]        word_position;
		logic [15:0]       pass_count;
	} res_t;

	typedef struct packed {
		logic [6:0] table_length;
		logic [7:0] retry_ticks;
		logic [7:0] write_interval;
	} cfg_t;

endpackage

// ===== rtl/core/pccs_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module pccs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== rtl/core/pccs_front.sv =====
// Front end: takes input transactions, decodes the opcode, queues commands.
// Depends on pccs_pkg.
module pccs_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    opcode,
	input  logic [5:0]                    word_index,
	input  logic [pccs_pkg::WORD_W-1:0]   word_value,
	input  logic                          palette_hit,
	input  logic                          palette_still_owned,
	output logic                          cmd_valid,
	output pccs_pkg::cmd_t                cmd,
	input  logic                          cmd_pop
);

	pccs_pkg::cmd_t   q_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	pccs_pkg::kind_t  kind;
	pccs_pkg::cmd_t   cmd_in;
	logic             do_push;
	logic             do_pop;

	always_comb begin
		unique case (opcode)
			pccs_pkg::OP_TICK: begin
				kind = pccs_pkg::K_TICK;
			end
			pccs_pkg::OP_LOAD: begin
				kind = (int'(word_index) < pccs_pkg::TABLE_DEPTH) ? pccs_pkg::K_LOAD
					: pccs_pkg::K_NOP;
			end
			pccs_pkg::OP_RESTART: begin
				kind = pccs_pkg::K_RESTART;
			end
			default: begin
				kind = pccs_pkg::K_NOP;
			end
		endcase
	end

	assign cmd_in.kind  = kind;
	assign cmd_in.idx   = word_index;
	assign cmd_in.value = word_value;
	assign cmd_in.found = palette_hit;
	assign cmd_in.owned = palette_still_owned;

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

// ===== rtl/core/pccs_back.sv =====
// Back end: sequencer state, colour table RAM and the result queue.
// Depends on pccs_pkg and pccs_ram.
module pccs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  pccs_pkg::cfg_t cfg,
	input  logic           cmd_valid,
	input  pccs_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           empty,
	input  logic           pop,
	output pccs_pkg::res_t result
);

	typedef enum logic [2:0] {
		PH_DEAD = 3'b001,
		PH_WAIT = 3'b010,
		PH_RUN  = 3'b100
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_STOP = 3'b010,
		ST_EMIT = 3'b100
	} st_t;

	phase_t phase_q, phase_d;
	st_t    st_q, st_d;
	logic [7:0]                    timer_q, timer_d;
	logic [pccs_pkg::ADDR_W-1:0]   position_q, pos_d;
	logic [pccs_pkg::ADDR_W-1:0]   emit_pos_q, emit_pos_d;
	logic [15:0]                   passes_q, passes_d;
	logic [pccs_pkg::WORD_W-1:0]   stop_q, stop_d;
	logic [pccs_pkg::LEN_W-1:0]    eff_len;
	logic [pccs_pkg::ADDR_W:0]     nxt;
	logic                          wrap;
	logic                          start;

	logic                          ram_we;
	logic [pccs_pkg::ADDR_W-1:0]   rd_a_addr, rd_b_addr;
	logic [pccs_pkg::WORD_W-1:0]   rd_a_data, rd_b_data;

	pccs_pkg::res_t oq_q [2];
	logic           oq_wr_q, oq_rd_q;
	logic [1:0]     oq_cnt_q;
	logic           res_push, res_pop;
	pccs_pkg::res_t res_d;

	assign eff_len = (int'(cfg.table_length) > pccs_pkg::TABLE_DEPTH)
		? pccs_pkg::LEN_W'(pccs_pkg::TABLE_DEPTH) : pccs_pkg::LEN_W'(cfg.table_length);
	assign start   = (st_q == ST_IDLE) && cmd_valid && (oq_cnt_q != 2'd2);
	assign cmd_pop = start;
	assign nxt     = {1'b0, emit_pos_q} + 1'b1;

	always_comb begin
		phase_d    = phase_q;
		st_d       = st_q;
		timer_d    = timer_q;
		pos_d      = position_q;
		passes_d   = passes_q;
		stop_d     = stop_q;
		emit_pos_d = emit_pos_q;
		ram_we     = 1'b0;
		rd_a_addr  = position_q;
		wrap       = 1'b0;
		res_push   = 1'b0;
		res_d.alive         = (phase_q != PH_DEAD);
		res_d.write_valid   = 1'b0;
		res_d.colour_word   = '0;
		res_d.word_position = '0;
		res_d.pass_count    = passes_q;
		unique case (st_q)
			ST_IDLE: begin
				if (start) begin
					unique case (cmd.kind)
						pccs_pkg::K_LOAD: begin
							ram_we   = 1'b1;
							res_push = 1'b1;
						end
						pccs_pkg::K_RESTART: begin
							rd_a_addr = '0;
							st_d      = ST_STOP;
							phase_d   = PH_WAIT;
							timer_d   = 8'd0;
							pos_d     = '0;
							passes_d  = 16'd0;
						end
						pccs_pkg::K_TICK: begin
							if (phase_q == PH_DEAD) begin
								res_push = 1'b1;
							end else if (eff_len == '0) begin
								phase_d     = PH_DEAD;
								res_d.alive = 1'b0;
								res_push    = 1'b1;
							end else if (timer_q != 8'd0) begin
								timer_d  = timer_q - 8'd1;
								res_push = 1'b1;
							end else if (phase_q == PH_WAIT && !cmd.found) begin
								timer_d  = (cfg.retry_ticks == 8'd0) ? 8'd0
									: cfg.retry_ticks - 8'd1;
								res_push = 1'b1;
							end else if (!cmd.owned) begin
								phase_d     = PH_DEAD;
								res_d.alive = 1'b0;
								res_push    = 1'b1;
							end else begin
								phase_d    = PH_RUN;
								rd_a_addr  = (phase_q == PH_WAIT) ? '0 : position_q;
								emit_pos_d = rd_a_addr;
								timer_d    = (cfg.write_interval == 8'd0) ? 8'd0
									: cfg.write_interval - 8'd1;
								st_d       = ST_EMIT;
							end
						end
						default: begin
							res_push = 1'b1;
						end
					endcase
				end
			end
			ST_STOP: begin
				stop_d   = (eff_len != '0) ? rd_a_data : '0;
				res_push = 1'b1;
				st_d     = ST_IDLE;
			end
			ST_EMIT: begin
				wrap = (nxt >= eff_len) || ((rd_b_data & pccs_pkg::WRAP_MARK) != '0)
					|| (rd_b_data == stop_q);
				pos_d    = wrap ? '0 : nxt[pccs_pkg::ADDR_W-1:0];
				passes_d = passes_q + {15'd0, wrap};
				res_d.alive         = 1'b1;
				res_d.write_valid   = 1'b1;
				res_d.colour_word   = rd_a_data;
				res_d.word_position = 6'(emit_pos_q);
				res_d.pass_count    = passes_d;
				res_push = 1'b1;
				st_d     = ST_IDLE;
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	assign rd_b_addr = rd_a_addr + pccs_pkg::ADDR_W'(1);

	pccs_ram #(
		.WIDTH(pccs_pkg::WORD_W),
		.DEPTH(pccs_pkg::TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (pccs_pkg::ADDR_W'(cmd.idx)),
		.wdata   (cmd.value),
		.raddr_a (rd_a_addr),
		.raddr_b (rd_b_addr),
		.rdata_a (rd_a_data),
		.rdata_b (rd_b_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_DEAD;
			st_q       <= ST_IDLE;
			timer_q    <= 8'd0;
			position_q <= '0;
			passes_q   <= 16'd0;
			stop_q     <= '0;
		end else begin
			phase_q    <= phase_d;
			st_q       <= st_d;
			timer_q    <= timer_d;
			position_q <= pos_d;
			passes_q   <= passes_d;
			stop_q     <= stop_d;
		end
	end

	always_ff @(posedge clk) begin
		emit_pos_q <= emit_pos_d;
	end

	// result queue
	assign empty   = (oq_cnt_q == 2'd0);
	assign result  = oq_q[oq_rd_q];
	assign res_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (res_push) begin
			oq_q[oq_wr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (res_push) begin
				oq_wr_q <= !oq_wr_q;
			end
			if (res_pop) begin
				oq_rd_q <= !oq_rd_q;
			end
			oq_cnt_q <= oq_cnt_q + {1'b0, res_push} - {1'b0, res_pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (oq_cnt_q != 2'd2))
		else $error("result queue overflow");

	a_emit_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT) |=> (st_q == ST_IDLE))
		else $error("emit state held");

	a_stop_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_STOP) |-> (phase_q == PH_WAIT))
		else $error("stop word latched outside wait phase");

	a_write_running: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_d.write_valid) |-> (res_d.alive && phase_q == PH_RUN))
		else $error("colour write while not running");

endmodule

// ===== rtl/core/palette_color_cycle_sequencer.sv =====
// Top level of the palette color-cycle sequencer: APB registers, front, back.
// Depends on pccs_pkg, pccs_front, pccs_back (and pccs_ram below it).
//
// Use: items enter through a queue-style port (push/full) and are accepted
// when push is high and full is low. Opcode tick advances the sequencer,
// load writes one word of the 64-entry color table, restart latches table
// word 0 as the stop word and waits for the palette. Every item gives one
// result, read queue-style (empty/pop) in item order.
// An accepted item is registered in the command queue. Loads, idle ticks
// and other items give their result as the back end takes them; restarts
// and ticks that emit a color word first wait on the registered table read
// (two read ports: emitted word and the next word for the wrap check).
// Throughput: one item per cycle while the result queue has room, except
// emitting ticks and restarts; the back end handles one item at a time.
// Stalls: a 2-entry command queue and a 2-entry result queue decouple the
// sides; when the result queue fills, the back end halts and full rises once
// the command queue fills. Reset: sequencer dead, counters zero, registers
// at their defaults; the table is undefined until loaded (no clearing pass).
// The user writes registers only while idle; the block does not enforce it.
module palette_color_cycle_sequencer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [3:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        push,
	output logic                        full,
	input  logic [1:0]                  opcode,
	input  logic [5:0]                  word_index,
	input  logic [pccs_pkg::WORD_W-1:0] word_value,
	input  logic                        palette_hit,
	input  logic                        palette_still_owned,
	output logic                        empty,
	input  logic                        pop,
	output logic                        alive,
	output logic                        write_valid,
	output logic [pccs_pkg::WORD_W-1:0] colour_word,
	output logic [5:0]                  word_position,
	output logic [15:0]                 pass_count
);

	pccs_pkg::cfg_t cfg_q;
	pccs_pkg::cmd_t cmd;
	pccs_pkg::res_t result;
	logic           cmd_valid;
	logic           cmd_pop;
	logic           reg_wr;
	logic [1:0]     reg_idx;

	assign pready  = 1'b1;
	assign reg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.table_length   <= pccs_pkg::TABLE_LENGTH_RESET;
			cfg_q.retry_ticks    <= pccs_pkg::RETRY_TICKS_RESET;
			cfg_q.write_interval <= pccs_pkg::WRITE_INTERVAL_RESET;
		end else if (reg_wr) begin
			unique case (reg_idx)
				pccs_pkg::REG_TABLE_LENGTH: begin
					cfg_q.table_length <= pwdata[6:0];
				end
				pccs_pkg::REG_RETRY_TICKS: begin
					cfg_q.retry_ticks <= pwdata[7:0];
				end
				pccs_pkg::REG_WRITE_INTERVAL: begin
					cfg_q.write_interval <= pwdata[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			pccs_pkg::REG_TABLE_LENGTH: begin
				prdata = {25'd0, cfg_q.table_length};
			end
			pccs_pkg::REG_RETRY_TICKS: begin
				prdata = {24'd0, cfg_q.retry_ticks};
			end
			pccs_pkg::REG_WRITE_INTERVAL: begin
				prdata = {24'd0, cfg_q.write_interval};
			end
			default: begin
				prdata = {30'd0, paddr[1:0]} & 32'd0;
			end
		endcase
	end

	pccs_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.push                (push),
		.full                (full),
		.opcode              (opcode),
		.word_index          (word_index),
		.word_value          (word_value),
		.palette_hit         (palette_hit),
		.palette_still_owned (palette_still_owned),
		.cmd_valid           (cmd_valid),
		.cmd                 (cmd),
		.cmd_pop             (cmd_pop)
	);

	pccs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	assign alive         = result.alive;
	assign write_valid   = result.write_valid;
	assign colour_word   = result.colour_word;
	assign word_position = result.word_position;
	assign pass_count    = result.pass_count;

endmodule

// ===== dv/pccs_checker.sv =====
// Checker for the palette color-cycle sequencer: watches the item, result and register ports.
// Keeps its own copy of the sequencer and compares every result it sees. Depends on pccs_pkg.
module pccs_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [3:0]                  paddr,
	input  logic [31:0]                 pwdata,
	input  logic [31:0]                 prdata,
	input  logic                        pready,
	input  logic                        push,
	input  logic                        full,
	input  logic [1:0]                  opcode,
	input  logic [5:0]                  word_index,
	input  logic [pccs_pkg::WORD_W-1:0] word_value,
	input  logic                        palette_hit,
	input  logic                        palette_still_owned,
	input  logic                        empty,
	input  logic                        pop,
	input  logic                        alive,
	input  logic                        write_valid,
	input  logic [pccs_pkg::WORD_W-1:0] colour_word,
	input  logic [5:0]                  word_position,
	input  logic [15:0]                 pass_count,
	output int                          mismatches,
	output int                          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {
		SEQ_DEAD,
		SEQ_WAIT,
		SEQ_RUN
	} seq_phase_t;

	pccs_pkg::cfg_t              cfg_q;
	seq_phase_t                  seq_phase;
	logic [7:0]                  tick_timer;
	logic [5:0]                  position;
	logic [15:0]                 passes;
	logic [pccs_pkg::WORD_W-1:0] stop_colour;
	logic [pccs_pkg::WORD_W-1:0] colour_table [pccs_pkg::TABLE_DEPTH];
	pccs_pkg::res_t              predicted_results [$];

	function automatic pccs_pkg::res_t predict_sequencer(input logic [1:0] op,
			input logic [5:0] idx, input logic [pccs_pkg::WORD_W-1:0] val, input logic found,
			input logic owned);
		pccs_pkg::res_t r;
		logic [6:0]     len;
		logic [6:0]     nxt;
		logic           wrap;
		r = '0;
		len = (cfg_q.table_length > pccs_pkg::TABLE_DEPTH) ? 7'(pccs_pkg::TABLE_DEPTH)
			: cfg_q.table_length;
		case (op)
			pccs_pkg::OP_LOAD: begin
				colour_table[idx] = val;
			end
			pccs_pkg::OP_RESTART: begin
				seq_phase = SEQ_WAIT;
				tick_timer = '0;
				position = '0;
				passes = '0;
				stop_colour = (len != 0) ? colour_table[0] : '0;
			end
			pccs_pkg::OP_TICK: begin
				if (seq_phase != SEQ_DEAD) begin
					if (len == 0) begin
						seq_phase = SEQ_DEAD;
					end else if (tick_timer != 0) begin
						tick_timer = tick_timer - 8'd1;
					end else begin
						if (seq_phase == SEQ_WAIT) begin
							if (found) begin
								position = '0;
								seq_phase = SEQ_RUN;
							end else begin
								tick_timer = (cfg_q.retry_ticks == 0) ? 8'd0 :
									cfg_q.retry_ticks - 8'd1;
							end
						end
						if (seq_phase == SEQ_RUN) begin
							if (!owned) begin
								seq_phase = SEQ_DEAD;
							end else begin
								r.write_valid = 1'b1;
								r.colour_word = colour_table[position];
								r.word_position = position;
								tick_timer = (cfg_q.write_interval == 0) ? 8'd0 :
									cfg_q.write_interval - 8'd1;
								nxt = {1'b0, position} + 7'd1;
								wrap = (nxt >= len);
								if (!wrap)
									wrap = ((colour_table[nxt[5:0]] & pccs_pkg::WRAP_MARK) != 0)
										|| (colour_table[nxt[5:0]] == stop_colour);
								if (wrap) begin
									nxt = '0;
									passes = passes + 16'd1;
								end
								position = nxt[5:0];
							end
						end
					end
				end
			end
			default: ;
		endcase
		r.alive = (seq_phase != SEQ_DEAD);
		r.pass_count = passes;
		return r;
	endfunction

	function automatic int field_differs(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pccs_pkg::res_t got;
		pccs_pkg::res_t want;
		int             errs;
		if (!arst_n) begin
			cfg_q.table_length <= pccs_pkg::TABLE_LENGTH_RESET;
			cfg_q.retry_ticks <= pccs_pkg::RETRY_TICKS_RESET;
			cfg_q.write_interval <= pccs_pkg::WRITE_INTERVAL_RESET;
			seq_phase <= SEQ_DEAD;
			tick_timer <= '0;
			position <= '0;
			passes <= '0;
			stop_colour <= '0;
			predicted_results.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			errs = 0;
			if (pop && !empty) begin
				got = {alive, write_valid, colour_word, word_position, pass_count};
				if (predicted_results.size() == 0) begin
					$display("%0t: result with no transaction outstanding: expected none, actual %h",
						$time, got);
					errs++;
				end else begin
					want = predicted_results.pop_front();
					errs += field_differs("alive", 32'(want.alive), 32'(got.alive));
					errs += field_differs("write_valid", 32'(want.write_valid),
						32'(got.write_valid));
					errs += field_differs("colour_word", 32'(want.colour_word),
						32'(got.colour_word));
					errs += field_differs("word_position", 32'(want.word_position),
						32'(got.word_position));
					errs += field_differs("pass_count", 32'(want.pass_count),
						32'(got.pass_count));
				end
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						pccs_pkg::REG_TABLE_LENGTH:   cfg_q.table_length = pwdata[6:0];
						pccs_pkg::REG_RETRY_TICKS:    cfg_q.retry_ticks = pwdata[7:0];
						pccs_pkg::REG_WRITE_INTERVAL: cfg_q.write_interval = pwdata[7:0];
						default: ;
					endcase
				end else begin
					case (paddr[3:2])
						pccs_pkg::REG_TABLE_LENGTH:
							errs += field_differs("table_length", {25'd0, cfg_q.table_length},
								prdata);
						pccs_pkg::REG_RETRY_TICKS:
							errs += field_differs("retry_ticks", {24'd0, cfg_q.retry_ticks},
								prdata);
						pccs_pkg::REG_WRITE_INTERVAL:
							errs += field_differs("write_interval", {24'd0, cfg_q.write_interval},
								prdata);
						default: ;
					endcase
				end
			end
			if (push && !full)
				predicted_results.push_back(predict_sequencer(opcode, word_index, word_value,
					palette_hit, palette_still_owned));
			mismatches <= mismatches + errs;
			outstanding <= predicted_results.size();
		end
	end

endmodule

// ===== dv/tb_palette_color_cycle_sequencer.sv =====
// Top of the sequencer testbench: clock, reset, register setup, item and pop stimulus, verdict.
// Depends on pccs_pkg, the palette_color_cycle_sequencer RTL and pccs_checker.
module tb_palette_color_cycle_sequencer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int         ITEM_TARGET = 1750;
	localparam int         STALL_LIMIT = 2000;
	localparam int         NUM_SETTINGS = 12;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [3:0]                  paddr = '0;
	logic [31:0]                 pwdata = '0;
	logic [31:0]                 prdata;
	logic                        pready;
	logic                        push = 1'b0;
	logic                        full;
	logic [1:0]                  opcode = pccs_pkg::OP_TICK;
	logic [5:0]                  word_index = '0;
	logic [pccs_pkg::WORD_W-1:0] word_value = '0;
	logic                        palette_hit = 1'b0;
	logic                        palette_still_owned = 1'b0;
	logic                        empty;
	logic                        pop = 1'b0;
	logic                        alive;
	logic                        write_valid;
	logic [pccs_pkg::WORD_W-1:0] colour_word;
	logic [5:0]                  word_position;
	logic [15:0]                 pass_count;

	int                          mismatches;
	int                          outstanding;
	int                          items_sent = 0;
	int                          tx_idle_pct = 25;
	int                          rx_idle_pct = 53;
	int                          stall_cycles = 0;
	logic [pccs_pkg::WORD_W-1:0] slot0_word = '0;

	palette_color_cycle_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full), .opcode(opcode), .word_index(word_index),
		.word_value(word_value), .palette_hit(palette_hit),
		.palette_still_owned(palette_still_owned),
		.empty(empty), .pop(pop), .alive(alive), .write_valid(write_valid),
		.colour_word(colour_word), .word_position(word_position), .pass_count(pass_count)
	);

	pccs_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full), .opcode(opcode), .word_index(word_index),
		.word_value(word_value), .palette_hit(palette_hit),
		.palette_still_owned(palette_still_owned),
		.empty(empty), .pop(pop), .alive(alive), .write_valid(write_valid),
		.colour_word(colour_word), .word_position(word_position), .pass_count(pass_count),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		pop <= arst_n && ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (psel && penable)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [5:0] idx,
			input logic [pccs_pkg::WORD_W-1:0] val, input logic found, input logic owned);
		if (items_sent < ITEM_TARGET / 3) begin
			tx_idle_pct = 25;
			rx_idle_pct = 53;
		end else if (items_sent < 2 * ITEM_TARGET / 3) begin
			tx_idle_pct = 53;
			rx_idle_pct = 25;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		opcode <= op;
		word_index <= idx;
		word_value <= val;
		palette_hit <= found;
		palette_still_owned <= owned;
		if (op == pccs_pkg::OP_LOAD && idx == 0)
			slot0_word = val;
		@(posedge clk);
		while (full)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [1:0] reg_idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {reg_idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_back_regs();
		apb_access(1'b0, pccs_pkg::REG_TABLE_LENGTH, '0);
		apb_access(1'b0, pccs_pkg::REG_RETRY_TICKS, '0);
		apb_access(1'b0, pccs_pkg::REG_WRITE_INTERVAL, '0);
	endtask

	task automatic configure(input logic [6:0] len, input logic [7:0] retry, input logic [7:0] ivl);
		drain();
		apb_access(1'b1, pccs_pkg::REG_TABLE_LENGTH, {$urandom} & ~32'h7F | 32'(len));
		apb_access(1'b1, pccs_pkg::REG_RETRY_TICKS, {$urandom} & ~32'hFF | 32'(retry));
		apb_access(1'b1, pccs_pkg::REG_WRITE_INTERVAL, {$urandom} & ~32'hFF | 32'(ivl));
		read_back_regs();
	endtask

	function automatic logic [pccs_pkg::WORD_W-1:0] pick_word();
		logic [pccs_pkg::WORD_W-1:0] v;
		int                          r;
		v = pccs_pkg::WORD_W'($urandom_range(16'hFFFF));
		r = $urandom_range(9);
		if (r < 7)
			v[15] = 1'b0;
		else if (r == 7)
			v = slot0_word;
		return v;
	endfunction

	task automatic send_random();
		int                          pick;
		logic [5:0]                  idx;
		logic [pccs_pkg::WORD_W-1:0] val;
		pick = $urandom_range(99);
		idx = 6'($urandom_range(63));
		val = pick_word();
		if (pick < 72)
			send_item(pccs_pkg::OP_TICK, idx, val, $urandom_range(99) < 65,
				$urandom_range(99) < 96);
		else if (pick < 84)
			send_item(pccs_pkg::OP_LOAD, idx, val, 1'($urandom), 1'($urandom));
		else if (pick < 95)
			send_item(pccs_pkg::OP_RESTART, idx, val, 1'($urandom), 1'($urandom));
		else if (pick < 97)
			send_item(OP_UNUSED, idx, val, 1'($urandom), 1'($urandom));
		else
			send_item(pccs_pkg::OP_TICK, idx, val, 1'($urandom), 1'($urandom));
	endtask

	logic [6:0] set_len   [NUM_SETTINGS] = '{7'd12, 7'd64, 7'd5, 7'd127, 7'd1, 7'd65,
		7'd0, 7'd40, 7'd3, 7'd20, 7'd2, 7'd64};
	logic [7:0] set_retry [NUM_SETTINGS] = '{8'd1, 8'd3, 8'd0, 8'd255, 8'd2, 8'd1,
		8'd4, 8'd1, 8'd255, 8'd2, 8'd1, 8'd1};
	logic [7:0] set_ivl   [NUM_SETTINGS] = '{8'd1, 8'd2, 8'd0, 8'd1, 8'd1, 8'd255,
		8'd2, 8'd3, 8'd255, 8'd0, 8'd1, 8'd1};

	initial begin
		logic [pccs_pkg::WORD_W-1:0] val;
		int                          per_phase;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: dead ticks, empty-table restart and kill
		read_back_regs();
		send_item(pccs_pkg::OP_TICK, 6'h3F, 16'hFFFF, 1'b1, 1'b1);
		send_item(pccs_pkg::OP_TICK, 6'h00, 16'h0000, 1'b0, 1'b0);
		send_item(OP_UNUSED, 6'h2A, 16'h5555, 1'b1, 1'b0);
		send_item(pccs_pkg::OP_RESTART, 6'h15, 16'hAAAA, 1'b0, 1'b1);
		send_item(pccs_pkg::OP_TICK, 6'h00, 16'h0000, 1'b1, 1'b1);
		send_item(pccs_pkg::OP_TICK, 6'h00, 16'h0000, 1'b1, 1'b1);

		// fill every slot before anything reads the table
		for (int i = 0; i < pccs_pkg::TABLE_DEPTH; i++) begin
			val = pccs_pkg::WORD_W'($urandom_range(16'hFFFF));
			if (i % 5 != 0 || i < 7)
				val[15] = 1'b0;
			case (i)
				0:  val = 16'h1234;
				1:  val = 16'h0000;
				2:  val = 16'h7FFF;
				6:  val = pccs_pkg::WRAP_MARK;
				63: val = 16'hFFFF;
				default: if (i < 6 && val == 16'h1234) val = 16'h0042;
			endcase
			send_item(pccs_pkg::OP_LOAD, 6'(i), val, 1'($urandom), 1'($urandom));
		end

		configure(7'd64, 8'd0, 8'd0);
		send_item(pccs_pkg::OP_RESTART, 6'h00, 16'h0000, 1'b0, 1'b0);
		send_item(pccs_pkg::OP_TICK, 6'h00, 16'h0000, 1'b0, 1'b1);
		for (int i = 0; i < 7; i++)
			send_item(pccs_pkg::OP_TICK, 6'h00, 16'h0000, 1'b1, 1'b1);
		send_item(pccs_pkg::OP_TICK, 6'h00, 16'h0000, 1'b1, 1'b1);
		// stop word planted at the position to be emitted next
		send_item(pccs_pkg::OP_LOAD, 6'd2, 16'h1234, 1'b0, 1'b0);
		send_item(pccs_pkg::OP_TICK, 6'h00, 16'h0000, 1'b1, 1'b1);
		send_item(pccs_pkg::OP_TICK, 6'h00, 16'h0000, 1'b1, 1'b1);
		send_item(pccs_pkg::OP_TICK, 6'h00, 16'h0000, 1'b1, 1'b0);
		send_item(pccs_pkg::OP_TICK, 6'h00, 16'h0000, 1'b1, 1'b1);
		send_item(pccs_pkg::OP_RESTART, 6'h00, 16'h0000, 1'b1, 1'b1);
		send_item(pccs_pkg::OP_TICK, 6'h00, 16'h0000, 1'b1, 1'b0);

		per_phase = (ITEM_TARGET - items_sent) / NUM_SETTINGS;
		for (int s = 0; s < NUM_SETTINGS; s++) begin
			configure(set_len[s], set_retry[s], set_ivl[s]);
			send_item(pccs_pkg::OP_RESTART, 6'h00, 16'h0000, 1'b0, 1'b0);
			for (int n = 0; n < per_phase; n++) begin
				if ($urandom_range(149) == 0)
					drain();
				send_random();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/pccs_pkg.sv
rtl/core/pccs_ram.sv
rtl/core/pccs_front.sv
rtl/core/pccs_back.sv
rtl/core/palette_color_cycle_sequencer.sv
dv/pccs_checker.sv
dv/tb_palette_color_cycle_sequencer.sv
